@@ rtl/qoi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qoi_pkg;

    // Color index geometry.
    localparam int IDX_DEPTH = 64;
    localparam int IDX_AW    = 6;

    // Width of the packed result payload on the master side.
    localparam int RES_DATA_W = 104;

    // Op tags of the byte stream. The two full-byte tags win over the
    // two-bit tags in the top bits.
    localparam logic [7:0] TAG_RGB  = 8'hFE;
    localparam logic [7:0] TAG_RGBA = 8'hFF;
    localparam logic [1:0] OP_INDEX = 2'b00;
    localparam logic [1:0] OP_DIFF  = 2'b01;
    localparam logic [1:0] OP_LUMA  = 2'b10;
    localparam logic [1:0] OP_RUN   = 2'b11;

    // What a result beat carries.
    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_HEADER   = 2'd1,
        KIND_CHAN_ERR = 2'd2
    } kind_t;

    // One result item as it travels through the output buffer.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  channel_count;
        logic        last;
    } res_t;

    // Color index hash (3r + 5g + 7b + 11a) mod 64. Only the low six bits of
    // each component can reach the low six bits of the sum.
    function automatic logic [IDX_AW-1:0] pixel_hash(input logic [31:0] px);
        logic [IDX_AW-1:0] r;
        logic [IDX_AW-1:0] g;
        logic [IDX_AW-1:0] b;
        logic [IDX_AW-1:0] a;
        r = px[24 +: IDX_AW];
        g = px[16 +: IDX_AW];
        b = px[8 +: IDX_AW];
        a = px[0 +: IDX_AW];
        return r * IDX_AW'(3) + g * IDX_AW'(5) + b * IDX_AW'(7) + a * IDX_AW'(11);
    endfunction

endpackage

`default_nettype wire

@@ rtl/qoi_image_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] raw file byte, header first
// m_axis    out  tuser kind, tlast last, tdata pixel or header values
//
// Header bytes and the bytes of RGB, RGBA, LUMA and DIFF ops need no wait
// state. An INDEX op waits in ST_INDEX_WAIT for the registered read of the
// color index RAM. A RUN op emits its length plus one copies of the previous
// pixel. Reset is asynchronous and clears the control state, the previous
// pixel and all index valid bits at once; no clearing pass is needed.
// s_axis_tready drops while the two-beat result buffer is full, during the
// index read and while a run is being emitted.
module qoi_image_stream_decoder_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // stream_byte
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata from bit 0 up: red, green, blue, alpha, image_width,
    // image_height, channel_count
    output logic      [qoi_pkg::RES_DATA_W-1:0]  m_axis_tdata,
    output logic      [1:0]                      m_axis_tuser,  // kind
    output logic                                 m_axis_tlast   // last
);

    // Decoder phases. Header collection, waiting for an op tag, collecting
    // the payload of RGB, RGBA and LUMA ops, waiting for an index read, and
    // emitting a run.
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_TAG,
        ST_RGB,
        ST_RGBA,
        ST_LUMA,
        ST_INDEX_WAIT,
        ST_RUN
    } state_t;

    localparam logic [3:0]  HDR_LAST     = 4'd13;
    localparam logic [3:0]  HDR_CHANNELS = 4'd12;
    localparam logic [31:0] PIXEL_RESET  = 32'h0000_00FF;

    state_t       state_reg,    state_next;
    logic [3:0]   byte_cnt_reg, byte_cnt_next;
    logic [23:0]  partial_reg,  partial_next;
    logic [31:0]  width_reg,    width_next;
    logic [31:0]  height_reg,   height_next;
    logic [31:0]  prev_reg,     prev_next;
    logic [5:0]   run_cnt_reg,  run_cnt_next;

    logic                          in_acc;
    logic [7:0]                    b;
    logic [31:0]                   pix_new;
    logic                          pix_done;
    logic [7:0]                    dg;
    logic [7:0]                    pr;
    logic [7:0]                    pg;
    logic [7:0]                    pb;
    logic [7:0]                    pa;

    logic                          res_push;
    qoi_pkg::res_t                 res;
    qoi_pkg::res_t                 head;
    logic                          fifo_full;
    logic                          res_pop;

    logic                          ram_clear;
    logic                          ram_we;
    logic [qoi_pkg::IDX_AW-1:0]    ram_waddr;
    logic [31:0]                   ram_wdata;
    logic                          ram_re;
    logic [31:0]                   ram_rdata;

    assign b      = s_axis_tdata;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign pr     = prev_reg[31:24];
    assign pg     = prev_reg[23:16];
    assign pb     = prev_reg[15:8];
    assign pa     = prev_reg[7:0];

    // Input is taken only while a result slot is guaranteed for it.
    assign s_axis_tready = !fifo_full && (state_reg != ST_INDEX_WAIT)
                           && (state_reg != ST_RUN);

    always_comb
    begin
        state_next    = state_reg;
        byte_cnt_next = byte_cnt_reg;
        partial_next  = partial_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        prev_next     = prev_reg;
        run_cnt_next  = run_cnt_reg;
        pix_new       = prev_reg;
        pix_done      = 1'b0;
        dg            = 8'd0;
        res_push      = 1'b0;
        res           = '0;
        ram_clear     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        case (state_reg)
            ST_HEADER:
            begin
                if (in_acc)
                begin
                    if (byte_cnt_reg inside {[4'd4:4'd7]})
                    begin
                        width_next = {width_reg[23:0], b};
                    end
                    else if (byte_cnt_reg inside {[4'd8:4'd11]})
                    begin
                        height_next = {height_reg[23:0], b};
                    end
                    else if (byte_cnt_reg == HDR_CHANNELS)
                    begin
                        partial_next = {16'd0, b};
                    end

                    if (byte_cnt_reg < HDR_LAST)
                    begin
                        byte_cnt_next = byte_cnt_reg + 4'd1;
                    end
                    else
                    begin
                        // The colorspace byte closes the header.
                        byte_cnt_next     = 4'd0;
                        partial_next      = 24'd0;
                        res_push          = 1'b1;
                        res.image_width   = width_reg;
                        res.image_height  = height_reg;
                        res.channel_count = partial_reg[7:0];
                        res.last          = 1'b1;
                        if (partial_reg == 24'd3 || partial_reg == 24'd4)
                        begin
                            res.kind   = qoi_pkg::KIND_HEADER;
                            prev_next  = PIXEL_RESET;
                            ram_clear  = 1'b1;
                            state_next = ST_TAG;
                        end
                        else
                        begin
                            res.kind   = qoi_pkg::KIND_CHAN_ERR;
                            state_next = ST_HEADER;
                        end
                    end
                end
            end

            ST_RGB:
            begin
                if (in_acc)
                begin
                    if (byte_cnt_reg < 4'd2)
                    begin
                        partial_next  = {partial_reg[15:0], b};
                        byte_cnt_next = byte_cnt_reg + 4'd1;
                    end
                    else
                    begin
                        byte_cnt_next = 4'd0;
                        pix_new       = {partial_reg[15:0], b, pa};
                        pix_done      = 1'b1;
                    end
                end
            end

            ST_RGBA:
            begin
                if (in_acc)
                begin
                    if (byte_cnt_reg < 4'd3)
                    begin
                        partial_next  = {partial_reg[15:0], b};
                        byte_cnt_next = byte_cnt_reg + 4'd1;
                    end
                    else
                    begin
                        byte_cnt_next = 4'd0;
                        pix_new       = {partial_reg, b};
                        pix_done      = 1'b1;
                    end
                end
            end

            ST_LUMA:
            begin
                if (in_acc)
                begin
                    dg       = {2'b00, partial_reg[5:0]} - 8'd32;
                    pix_new  = {pr + dg + {4'd0, b[7:4]} - 8'd8,
                                pg + dg,
                                pb + dg + {4'd0, b[3:0]} - 8'd8,
                                pa};
                    pix_done = 1'b1;
                end
            end

            ST_INDEX_WAIT:
            begin
                pix_new  = ram_rdata;
                pix_done = 1'b1;
            end

            ST_RUN:
            begin
                // One copy of the previous pixel per free buffer slot.
                if (!fifo_full)
                begin
                    res_push  = 1'b1;
                    res.red   = pr;
                    res.green = pg;
                    res.blue  = pb;
                    res.alpha = pa;
                    if (run_cnt_reg == 6'd0)
                    begin
                        res.last   = 1'b1;
                        state_next = ST_TAG;
                    end
                    else
                    begin
                        run_cnt_next = run_cnt_reg - 6'd1;
                    end
                end
            end

            default:
            begin
                // Waiting for an op tag; unused codes behave the same way.
                if (in_acc)
                begin
                    if (b == qoi_pkg::TAG_RGB)
                    begin
                        state_next    = ST_RGB;
                        byte_cnt_next = 4'd0;
                        partial_next  = 24'd0;
                    end
                    else if (b == qoi_pkg::TAG_RGBA)
                    begin
                        state_next    = ST_RGBA;
                        byte_cnt_next = 4'd0;
                        partial_next  = 24'd0;
                    end
                    else
                    begin
                        case (b[7:6])
                            qoi_pkg::OP_INDEX:
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_INDEX_WAIT;
                            end
                            qoi_pkg::OP_DIFF:
                            begin
                                pix_new  = {pr + {6'd0, b[5:4]} - 8'd2,
                                            pg + {6'd0, b[3:2]} - 8'd2,
                                            pb + {6'd0, b[1:0]} - 8'd2,
                                            pa};
                                pix_done = 1'b1;
                            end
                            qoi_pkg::OP_LUMA:
                            begin
                                state_next    = ST_LUMA;
                                partial_next  = {16'd0, b};
                                byte_cnt_next = 4'd0;
                            end
                            default:
                            begin
                                // Run: the previous pixel goes into the index
                                // now, the copies follow one per cycle while the result buffer has room.
                                ram_we       = 1'b1;
                                run_cnt_next = b[5:0];
                                partial_next = 24'd0;
                                state_next   = ST_RUN;
                            end
                        endcase
                    end
                end
            end
        endcase

        if (pix_done)
        begin
            prev_next    = pix_new;
            ram_we       = 1'b1;
            res_push     = 1'b1;
            res.red      = pix_new[31:24];
            res.green    = pix_new[23:16];
            res.blue     = pix_new[15:8];
            res.alpha    = pix_new[7:0];
            res.last     = 1'b1;
            state_next   = ST_TAG;
            partial_next = 24'd0;
        end
    end

    // Every write stores the pixel in hand (new or previous) at its hash.
    assign ram_wdata = pix_new;
    assign ram_waddr = qoi_pkg::pixel_hash(pix_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HEADER;
            byte_cnt_reg <= 4'd0;
            partial_reg  <= 24'd0;
            width_reg    <= 32'd0;
            height_reg   <= 32'd0;
            prev_reg     <= PIXEL_RESET;
            run_cnt_reg  <= 6'd0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
            partial_reg  <= partial_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            prev_reg     <= prev_next;
            run_cnt_reg  <= run_cnt_next;
        end
    end

    qoi_index_ram u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (ram_clear),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (b[qoi_pkg::IDX_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign res_pop = m_axis_tvalid && m_axis_tready;

    qoi_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .pop       (res_pop),
        .head      (head),
        .not_empty (m_axis_tvalid),
        .full      (fifo_full)
    );

    assign m_axis_tdata = {head.channel_count, head.image_height, head.image_width,
                           head.alpha, head.blue, head.green, head.red};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    // A result is never pushed into a full buffer.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && fifo_full))
        else $error("result pushed into full buffer");

    // An accepted index tag is followed by the read-wait state, then tag decoding.
    a_index_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && state_reg == ST_TAG && b[7:6] == qoi_pkg::OP_INDEX)
        |=> (state_reg == ST_INDEX_WAIT) ##1 (state_reg == ST_TAG))
        else $error("index read did not complete in one cycle");

    // The final copy of a run carries last and returns to tag decoding.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !fifo_full && run_cnt_reg == 6'd0)
        |-> (res.last ##1 state_reg == ST_TAG))
        else $error("run did not end with last");

    // Header and error beats always close their byte.
    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != qoi_pkg::KIND_PIXEL) |-> m_axis_tlast)
        else $error("header beat without last");

endmodule

`default_nettype wire

@@ rtl/qoi_index_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 64-entry color index with a synchronous, registered read. A valid bit per
// entry lets reset and a new header clear the whole index at once; an entry
// that was never written reads as zero.
module qoi_index_ram (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clear,
    input  wire logic                        we,
    input  wire logic [qoi_pkg::IDX_AW-1:0]  waddr,
    input  wire logic [31:0]                 wdata,
    input  wire logic                        re,
    input  wire logic [qoi_pkg::IDX_AW-1:0]  raddr,
    output logic      [31:0]                 rdata
);

    logic [31:0]                    mem [qoi_pkg::IDX_DEPTH];
    logic [qoi_pkg::IDX_DEPTH-1:0]  valid_reg;
    logic [31:0]                    rdata_reg;
    logic                           rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 32'd0;

endmodule

`default_nettype wire

@@ rtl/qoi_res_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result buffer between the decoder and the master side.
module qoi_res_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire qoi_pkg::res_t push_data,
    input  wire logic          pop,
    output qoi_pkg::res_t      head,
    output logic               not_empty,
    output logic               full
);

    qoi_pkg::res_t entry [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_pop;

    assign do_pop    = pop && (count_reg != 2'd0);
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head      = entry[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int          HEADER_BYTES    = 14;
    localparam int          RANDOM_BYTES    = 215;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          DRAIN_CYCLES    = 120;
    localparam int          PLAN_DEPTH      = 512;
    localparam int          WANT_DEPTH      = 256;
    localparam int unsigned CYCLE_LIMIT     = 1_200_000;

    typedef enum logic [2:0] {
        ST_HEADER = 3'd0,
        ST_TAG    = 3'd1,
        ST_RGB    = 3'd2,
        ST_RGBA   = 3'd3,
        ST_LUMA   = 3'd4
    } dec_state_t;

    // One byte waiting to be sent. A typed beat carries the result that the
    // byte must produce, written down by hand.
    typedef struct {
        logic [7:0]     data;
        bit             typed;
        qoi_pkg::res_t  want;
    } plan_beat_t;

    // One row of the directed table: a header, an op or the end marker, bytes in file order.
    typedef struct {
        int unsigned    len;
        logic [111:0]   bytes;
        bit             typed;
        qoi_pkg::res_t  want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = 8'd0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [qoi_pkg::RES_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]                      m_axis_tuser;
    logic                            m_axis_tlast;

    qoi_image_stream_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // Decoder state mirrored by the predictor.
    dec_state_t   dec_state;
    logic [3:0]   beat_pos;
    logic [31:0]  hdr_width;
    logic [31:0]  hdr_height;
    logic [23:0]  partial;
    logic [31:0]  last_pixel;     // r 31..24, g 23..16, b 15..8, a 7..0
    logic [31:0]  color_table [64];

    // Expected results in a ring, bytes to send in a flat list.
    qoi_pkg::res_t  want_buf [WANT_DEPTH];
    int             want_wr = 0;
    int             want_rd = 0;
    plan_beat_t     byte_plan [PLAN_DEPTH];
    int             plan_wr = 0;
    int             plan_rd = 0;
    stim_row_t      directed_rows [13];

    int           plan_total = 0;
    int           bytes_accepted = 0;
    int           mismatches = 0;
    int unsigned  cycle_count = 0;
    logic         hold_off = 1'b0;

    function automatic logic [5:0] index_slot(input logic [31:0] px);
        logic [31:0] sum;
        sum = 3 * px[31:24] + 5 * px[23:16] + 7 * px[15:8] + 11 * px[7:0];
        return sum[5:0];
    endfunction

    task automatic want_store(input qoi_pkg::res_t r);
        if (want_wr - want_rd >= WANT_DEPTH)
        begin
            $error("expected result ring overflowed");
            mismatches++;
        end
        want_buf[want_wr[7:0]] = r;
        want_wr++;
    endtask

    task automatic plan_add(input plan_beat_t p);
        byte_plan[plan_wr[8:0]] = p;
        plan_wr++;
    endtask

    task automatic clear_pixels();
        last_pixel = {8'd0, 8'd0, 8'd0, 8'd255};
        foreach (color_table[i])
            color_table[i] = 32'd0;
    endtask

    task automatic push_pixel(input logic [31:0] px, input logic last);
        qoi_pkg::res_t r;
        r = '{qoi_pkg::KIND_PIXEL, px[31:24], px[23:16], px[15:8], px[7:0],
              32'd0, 32'd0, 8'd0, last};
        want_store(r);
    endtask

    // Every completed op makes the new pixel current and files it in the index.
    task automatic finish_pixel(input logic [31:0] px);
        last_pixel = px;
        color_table[index_slot(px)] = px;
        push_pixel(px, 1'b1);
        dec_state = ST_TAG;
        partial = 24'd0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [7:0]     pr;
        logic [7:0]     pg;
        logic [7:0]     pb;
        logic [7:0]     pa;
        logic [7:0]     dg;
        logic [7:0]     nr;
        logic [7:0]     ng;
        logic [7:0]     nb;
        logic [3:0]     n;
        qoi_pkg::res_t  r;
        pr = last_pixel[31:24];
        pg = last_pixel[23:16];
        pb = last_pixel[15:8];
        pa = last_pixel[7:0];
        case (dec_state)
            ST_HEADER:
            begin
                n = beat_pos;
                if (n >= 4 && n <= 7)
                    hdr_width = {hdr_width[23:0], b};
                else if (n >= 8 && n <= 11)
                    hdr_height = {hdr_height[23:0], b};
                else if (n == 12)
                    partial = {16'd0, b};
                if (n < HEADER_BYTES - 1)
                begin
                    beat_pos = n + 4'd1;
                end
                else
                begin
                    beat_pos = 4'd0;
                    r = '{qoi_pkg::KIND_CHAN_ERR, 8'd0, 8'd0, 8'd0, 8'd0,
                          hdr_width, hdr_height, partial[7:0], 1'b1};
                    if (partial == 24'd3 || partial == 24'd4)
                    begin
                        r.kind = qoi_pkg::KIND_HEADER;
                        clear_pixels();
                        dec_state = ST_TAG;
                    end
                    else
                    begin
                        // A bad channel count sends the block back to the header.
                        dec_state = ST_HEADER;
                    end
                    want_store(r);
                    partial = 24'd0;
                end
            end
            ST_RGB:
            begin
                if (beat_pos < 2)
                begin
                    partial = {partial[15:0], b};
                    beat_pos = beat_pos + 4'd1;
                end
                else
                begin
                    beat_pos = 4'd0;
                    finish_pixel({partial[15:8], partial[7:0], b, pa});
                end
            end
            ST_RGBA:
            begin
                if (beat_pos < 3)
                begin
                    partial = {partial[15:0], b};
                    beat_pos = beat_pos + 4'd1;
                end
                else
                begin
                    beat_pos = 4'd0;
                    finish_pixel({partial[23:16], partial[15:8], partial[7:0], b});
                end
            end
            ST_LUMA:
            begin
                dg = {2'b00, partial[5:0]} - 8'd32;
                nr = pr + dg + ({4'd0, b[7:4]} - 8'd8);
                ng = pg + dg;
                nb = pb + dg + ({4'd0, b[3:0]} - 8'd8);
                finish_pixel({nr, ng, nb, pa});
            end
            default:
            begin
                // Waiting for an op tag.
                if (b == qoi_pkg::TAG_RGB || b == qoi_pkg::TAG_RGBA)
                begin
                    dec_state = (b == qoi_pkg::TAG_RGB) ? ST_RGB : ST_RGBA;
                    beat_pos = 4'd0;
                    partial = 24'd0;
                end
                else
                begin
                    case (b[7:6])
                        qoi_pkg::OP_INDEX:
                            finish_pixel(color_table[b[5:0]]);
                        qoi_pkg::OP_DIFF:
                        begin
                            nr = pr + {6'd0, b[5:4]} - 8'd2;
                            ng = pg + {6'd0, b[3:2]} - 8'd2;
                            nb = pb + {6'd0, b[1:0]} - 8'd2;
                            finish_pixel({nr, ng, nb, pa});
                        end
                        qoi_pkg::OP_LUMA:
                        begin
                            dec_state = ST_LUMA;
                            partial = {16'd0, b};
                            beat_pos = 4'd0;
                        end
                        default:
                        begin
                            // A run files the repeated pixel in the index too.
                            color_table[index_slot(last_pixel)] = last_pixel;
                            for (int k = 0; k <= int'(b[5:0]); k++)
                                push_pixel(last_pixel, k == int'(b[5:0]));
                            dec_state = ST_TAG;
                            partial = 24'd0;
                        end
                    endcase
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic plan_byte(input logic [7:0] b);
        plan_beat_t p;
        p.data = b;
        p.typed = 1'b0;
        p.want = '0;
        plan_add(p);
    endtask

    // Input and output beats are handled in one process at the rising edge:
    // accepted bytes feed the predictor before result beats are checked.
    always @(posedge clk)
    begin : stream_driver
        plan_beat_t     beat;
        qoi_pkg::res_t  want;
        int             mode;
        int             send_idle;
        int             recv_idle;
        int             slot;
        bit             offer;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                beat = byte_plan[plan_rd[8:0]];
                plan_rd++;
                decode_byte(beat.data);
                if (beat.typed)
                begin
                    // The hand-typed result stands in for the predicted one.
                    slot = want_wr - 1;
                    want_buf[slot[7:0]] = beat.want;
                end
                bytes_accepted++;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (want_wr == want_rd)
                begin
                    $error("result beat with no expectation: kind %0d data 0x%0h",
                           m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = want_buf[want_rd[7:0]];
                    want_rd++;
                    compare_field("kind", want.kind, m_axis_tuser);
                    compare_field("red", want.red, m_axis_tdata[7:0]);
                    compare_field("green", want.green, m_axis_tdata[15:8]);
                    compare_field("blue", want.blue, m_axis_tdata[23:16]);
                    compare_field("alpha", want.alpha, m_axis_tdata[31:24]);
                    compare_field("image_width", want.image_width, m_axis_tdata[63:32]);
                    compare_field("image_height", want.image_height, m_axis_tdata[95:64]);
                    compare_field("channel_count", want.channel_count,
                                  m_axis_tdata[103:96]);
                    compare_field("last", want.last, m_axis_tlast);
                end
            end

            // Idling: receiver-heavy third, sender-heavy third, then none.
            mode = (bytes_accepted * 3) / plan_total;
            send_idle = (mode == 0) ? 38 : (mode == 1) ? 54 : 0;
            recv_idle = (mode == 0) ? 54 : (mode == 1) ? 38 : 0;

            if (!s_axis_tvalid || s_axis_tready)
            begin
                offer = plan_wr != plan_rd && $urandom_range(0, 99) >= send_idle;
                s_axis_tvalid <= offer;
                if (offer)
                    s_axis_tdata <= byte_plan[plan_rd[8:0]].data;
            end
            m_axis_tready <= !hold_off && $urandom_range(0, 99) >= recv_idle;
        end
    end

    // Once the idle-free third starts, the receiver stops for a long stretch
    // while bytes keep coming, so the result buffer fills and the input stalls.
    initial
    begin : long_hold_off
        wait (plan_total != 0 && bytes_accepted * 3 >= plan_total * 2);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("qoi_image_stream_decoder_unit verification failed");
        $finish;
    end

    initial
    begin : run_sequence
        plan_beat_t p;
        int         pick;
        int         random_start;
        dec_state = ST_HEADER;
        beat_pos = 4'd0;
        hdr_width = 32'd0;
        hdr_height = 32'd0;
        partial = 24'd0;
        clear_pixels();

        // Bad channel count 0x83, with a low nibble of 3, then a good header, then
        // every op, the end marker last.
        directed_rows = '{
            '{14, 112'h716f6966_FFFFFFFF_00000000_83_00, 1'b1,
              '{qoi_pkg::KIND_CHAN_ERR, 8'd0, 8'd0, 8'd0, 8'd0,
                32'hFFFF_FFFF, 32'd0, 8'h83, 1'b1}},
            '{14, 112'h716f6966_00000000_FFFFFFFF_04_01, 1'b1,
              '{qoi_pkg::KIND_HEADER, 8'd0, 8'd0, 8'd0, 8'd0,
                32'd0, 32'hFFFF_FFFF, 8'h04, 1'b1}},
            // Plus one on each color from the fresh previous pixel.
            '{1, 112'h7F, 1'b1,
              '{qoi_pkg::KIND_PIXEL, 8'd1, 8'd1, 8'd1, 8'd255,
                32'd0, 32'd0, 8'd0, 1'b1}},
            // Slot zero was never written since the header.
            '{1, 112'h00, 1'b1,
              '{qoi_pkg::KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0,
                32'd0, 32'd0, 8'd0, 1'b1}},
            '{4, 112'hFE_FF_00_80, 1'b0, '0},
            '{5, 112'hFF_00_FF_7F_00, 1'b0, '0},
            '{1, 112'h40, 1'b0, '0},
            '{2, 112'h80_00, 1'b0, '0},
            '{2, 112'hBF_FF, 1'b0, '0},
            '{1, 112'hC0, 1'b0, '0},
            '{1, 112'hFD, 1'b0, '0},
            '{1, 112'h3F, 1'b0, '0},
            '{8, 112'h00_00_00_00_00_00_00_01, 1'b0, '0}
        };

        foreach (directed_rows[i])
        begin
            for (int k = 0; k < int'(directed_rows[i].len); k++)
            begin
                p.data = directed_rows[i].bytes[8 * (directed_rows[i].len - 1 - k) +: 8];
                p.typed = directed_rows[i].typed && (k == int'(directed_rows[i].len) - 1);
                p.want = directed_rows[i].want;
                plan_add(p);
            end
        end

        // Random ops with random content; runs are mostly short.
        random_start = plan_wr;
        while (plan_wr - random_start < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                plan_byte(qoi_pkg::TAG_RGB);
                repeat (3) plan_byte(8'($urandom));
            end
            else if (pick < 30)
            begin
                plan_byte(qoi_pkg::TAG_RGBA);
                repeat (4) plan_byte(8'($urandom));
            end
            else if (pick < 45)
                plan_byte({qoi_pkg::OP_INDEX, 6'($urandom)});
            else if (pick < 62)
                plan_byte({qoi_pkg::OP_DIFF, 6'($urandom)});
            else if (pick < 78)
            begin
                plan_byte({qoi_pkg::OP_LUMA, 6'($urandom)});
                plan_byte(8'($urandom));
            end
            else if (pick < 90)
                plan_byte({qoi_pkg::OP_RUN, 6'($urandom_range(0, 7))});
            else if (pick < 93)
                plan_byte({qoi_pkg::OP_RUN, 6'($urandom_range(8, 61))});
            else
                plan_byte(8'($urandom));
        end
        plan_total = plan_wr;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (plan_wr != plan_rd || s_axis_tvalid || want_wr != want_rd);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (want_wr != want_rd)
        begin
            $error("%0d expected results never arrived", want_wr - want_rd);
            mismatches++;
        end
        if (mismatches == 0)
            $display("qoi_image_stream_decoder_unit verification clean");
        else
            $display("qoi_image_stream_decoder_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/qoi_pkg.sv
rtl/qoi_index_ram.sv
rtl/qoi_res_fifo.sv
rtl/qoi_image_stream_decoder_unit.sv
test/testbench.sv
